// ----- design/afhc_pkg.sv -----
// ----------------------------------------------------------------------------
// afhc_pkg: shared constants for the autofocus hill-climb controller
// Phase codes, decision codes, config register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package afhc_pkg;

  // field widths
  localparam int SHARP_W    = 31;
  localparam int TH_W       = 16;
  localparam int STEP_W     = 7;
  localparam int FSTEP_W    = 5;
  localparam int PHASE_W    = 3;
  localparam int POS_OUT_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = SHARP_W + TH_W;
  localparam int DEC_W      = 3;

  // search phases
  localparam logic [PHASE_W-1:0] PH_COARSE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FINE    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PROBE_R = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PROBE_L = 3'd4;

  // probe decisions
  localparam logic [DEC_W-1:0] DEC_FLAT      = 3'd0;
  localparam logic [DEC_W-1:0] DEC_LOCAL_MAX = 3'd1;
  localparam logic [DEC_W-1:0] DEC_LEFT      = 3'd2;
  localparam logic [DEC_W-1:0] DEC_RIGHT     = 3'd3;
  localparam logic [DEC_W-1:0] DEC_WIDEN     = 3'd4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_TRACK_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THRESHOLD = 3'd4;

  // config reset values
  localparam logic [STEP_W-1:0]  RST_COARSE_STEP     = 7'd20;
  localparam logic [FSTEP_W-1:0] RST_FINE_STEP       = 5'd2;
  localparam logic [STEP_W-1:0]  RST_TRACK_STEP      = 7'd8;
  localparam logic [STEP_W-1:0]  RST_WIDE_TRACK_STEP = 7'd16;
  localparam logic [TH_W-1:0]    RST_RATIO_THRESHOLD = 16'd200;

endpackage

// ----- design/autofocus_hill_climb_controller.sv -----
// ----------------------------------------------------------------------------
// autofocus_hill_climb_controller: contrast autofocus hill-climb sequencer
// Takes one frame sharpness per item and returns the next lens position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries frame_sharpness_i and
//   refocus_request_i. Output channel (out_valid_o / out_stall_i) carries
//   focus_position_o and search_phase_o, one result per item.
//   The config port (cfg_we_i, cfg_index_i, cfg_wdata_i) writes the step
//   sizes and ratio threshold; write only while the block is idle.
// Sequencing:
//   An accepted item moves to the done state, and its result is written to
//   the output register when that register is free; the next item can be
//   accepted once the result is committed. A left-probe item with a nonzero
//   ratio_threshold first runs the ratio test as a shift-add multiply on one
//   adder, one threshold bit per cycle, up to the top set bit of
//   ratio_threshold.
//   One item is worked on at a time; in_stall_o is high while it runs.
// Stall:
//   A result sits in an output register. The next item is accepted while it
//   waits; that item's result is held back until the register drains.
// Reset:
//   Config returns to defaults, search restarts at the coarse sweep with the
//   lens at -1 (first result is position coarse step - 1). No clearing pass.
// ----------------------------------------------------------------------------
module autofocus_hill_climb_controller
  import afhc_pkg::*;
#(
  parameter int FOCUS_MAX = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SHARP_W-1:0]    frame_sharpness_i,
  input  logic                  refocus_request_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [POS_OUT_W-1:0]  focus_position_o,
  output logic [PHASE_W-1:0]    search_phase_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int LW = $clog2(FOCUS_MAX + 1);
  localparam int WW = LW + 9;
  localparam logic signed [WW-1:0] MAX_X = WW'(FOCUS_MAX);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  function automatic logic signed [LW:0] clip_pos(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v;
    if (v > MAX_X) r = MAX_X;
    else if (v < 0) r = '0;
    return (LW+1)'(r);
  endfunction

  // config
  logic [STEP_W-1:0]  coarse_q, track_q, wide_q;
  logic [FSTEP_W-1:0] fine_q;
  logic [TH_W-1:0]    ratio_q;

  // search state
  logic [1:0]           state_q;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic signed [LW:0]   lens_q, lens_d;
  logic [LW-1:0]        limit_q, limit_d;
  logic [STEP_W-1:0]    pd_q, pd_d;
  logic [SHARP_W-1:0]   best_s_q, best_s_d;
  logic signed [LW:0]   best_p_q, best_p_d;
  logic                 first_q, first_d;
  logic [SHARP_W-1:0]   right_q, right_d;
  logic                 pend_q, pend_clr;

  // item datapath
  logic [SHARP_W-1:0]   s_q, diff_q;
  logic                 r_gt_q;
  logic [PROD_W-1:0]    acc_q, mcand_q;
  logic [TH_W-1:0]      mplier_q;

  // output register
  logic                 out_valid_q;
  logic [POS_OUT_W-1:0] pos_out_q;
  logic [PHASE_W-1:0]   phase_out_q;

  logic in_acc, out_free, commit;
  logic [DEC_W-1:0] dec;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_DONE) && out_free;

  assign out_valid_o      = out_valid_q;
  assign focus_position_o = pos_out_q;
  assign search_phase_o   = phase_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_q <= RST_COARSE_STEP;
      fine_q   <= RST_FINE_STEP;
      track_q  <= RST_TRACK_STEP;
      wide_q   <= RST_WIDE_TRACK_STEP;
      ratio_q  <= RST_RATIO_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COARSE_STEP:     coarse_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_FINE_STEP:       fine_q   <= cfg_wdata_i[FSTEP_W-1:0];
        CFG_TRACK_STEP:      track_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_WIDE_TRACK_STEP: wide_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_RATIO_THRESHOLD: ratio_q  <= cfg_wdata_i[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // widened working copies
  logic [STEP_W-1:0]    cstep, fstep;
  logic signed [WW-1:0] lens_x, lim_x, cstep_x, fstep_x, half_x, pd_x, best_new_x;
  logic                 hit;
  logic signed [LW:0]   best_new;

  assign cstep      = (coarse_q == '0) ? STEP_W'(1) : coarse_q;
  assign fstep      = (fine_q == '0) ? STEP_W'(1) : STEP_W'(fine_q);
  assign lens_x     = WW'(lens_q);
  assign lim_x      = WW'($signed({1'b0, limit_q}));
  assign cstep_x    = WW'($signed({1'b0, cstep}));
  assign fstep_x    = WW'($signed({1'b0, fstep}));
  assign half_x     = WW'($signed({1'b0, cstep[STEP_W-1:1]}));
  assign pd_x       = WW'($signed({1'b0, pd_q}));
  assign hit        = first_q || (s_q > best_s_q);
  assign best_new   = hit ? lens_q : best_p_q;
  assign best_new_x = WW'(best_new);

  // left-probe decision; left sharpness equals current, so only the right
  // difference matters. Significant means floor(diff / s) >= threshold.
  logic sig;
  assign sig = ({{TH_W{1'b0}}, diff_q} >= acc_q);

  always_comb begin
    dec = DEC_FLAT;
    if (s_q != '0 && pd_q <= track_q) begin
      if (ratio_q == '0) begin
        dec = (r_gt_q && diff_q >= s_q) ? DEC_RIGHT : DEC_WIDEN;
      end else if (sig) begin
        dec = r_gt_q ? DEC_RIGHT : DEC_LEFT;
      end
    end
  end

  logic signed [WW-1:0] lens_n, lim_n;

  always_comb begin
    phase_d  = phase_q;
    lens_n   = lens_x;
    lim_n    = lim_x;
    pd_d     = pd_q;
    best_s_d = best_s_q;
    best_p_d = best_p_q;
    first_d  = first_q;
    right_d  = right_q;
    pend_clr = 1'b0;
    case (phase_q)
      PH_COARSE: begin
        if (hit) begin
          best_s_d = s_q;
          best_p_d = lens_q;
        end
        first_d = 1'b0;
        if (lens_x > lim_x - cstep_x) begin
          lim_n   = best_new_x + half_x;
          lens_n  = best_new_x - half_x;
          first_d = 1'b1;
          phase_d = PH_FINE;
        end else begin
          lens_n = lens_x + cstep_x;
        end
      end
      PH_FINE: begin
        if (hit) begin
          best_s_d = s_q;
          best_p_d = lens_q;
        end
        first_d = 1'b0;
        if (lens_x > lim_x - fstep_x) begin
          lens_n  = best_new_x;
          pd_d    = track_q;
          phase_d = PH_HOLD;
        end else begin
          lens_n = lens_x + fstep_x;
        end
      end
      PH_HOLD: begin
        if (pend_q) begin
          pend_clr = 1'b1;
          phase_d  = PH_COARSE;
          lim_n    = MAX_X;
          first_d  = 1'b1;
        end else begin
          phase_d = PH_PROBE_R;
          right_d = '0;
          lens_n  = lens_x + pd_x;
        end
      end
      PH_PROBE_R: begin
        phase_d = PH_PROBE_L;
        right_d = s_q;
        lens_n  = lens_x - pd_x - pd_x;
      end
      PH_PROBE_L: begin
        phase_d = PH_HOLD;
        case (dec)
          DEC_RIGHT: begin
            lens_n = lens_x + pd_x + pd_x;
            pd_d   = track_q;
          end
          DEC_LEFT: pd_d = track_q;
          DEC_WIDEN: begin
            pd_d   = wide_q;
            lens_n = lens_x + WW'($signed({1'b0, wide_q}));
          end
          default: begin
            lens_n = lens_x + pd_x;
            pd_d   = track_q;
          end
        endcase
      end
      default: ;
    endcase
    lens_d  = clip_pos(lens_n);
    limit_d = LW'(clip_pos(lim_n));
  end

  // sequencer and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_COARSE;
      lens_q   <= '1;
      limit_q  <= LW'(FOCUS_MAX);
      pd_q     <= '0;
      best_s_q <= '0;
      best_p_q <= '0;
      first_q  <= 1'b1;
      right_q  <= '0;
      pend_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pend_q  <= pend_q | refocus_request_i;
            state_q <= (phase_q == PH_PROBE_L && ratio_q != '0) ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          if ((mplier_q >> 1) == '0) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q  <= S_IDLE;
            phase_q  <= phase_d;
            lens_q   <= lens_d;
            limit_q  <= limit_d;
            pd_q     <= pd_d;
            best_s_q <= best_s_d;
            best_p_q <= best_p_d;
            first_q  <= first_d;
            right_q  <= right_d;
            if (pend_clr) pend_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item datapath: captures sharpness and right difference, then shift-add multiply of threshold by sharpness
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q      <= frame_sharpness_i;
      r_gt_q   <= right_q > frame_sharpness_i;
      diff_q   <= (right_q > frame_sharpness_i) ? right_q - frame_sharpness_i
                                                : frame_sharpness_i - right_q;
      acc_q    <= '0;
      mcand_q  <= PROD_W'(frame_sharpness_i);
      mplier_q <= ratio_q;
    end else if (state_q == S_MUL) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      pos_out_q   <= POS_OUT_W'(lens_d);
      phase_out_q <= phase_d;
    end
  end

  // checks
  a_lens_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lens_q <= (LW+1)'(FOCUS_MAX)) && (lens_q >= -1))
    else $error("lens position out of range");

  a_mul_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (mplier_q != '0))
    else $error("multiply step with empty multiplier");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("result committed over a waiting result");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q <= PH_PROBE_L) && (search_phase_o <= PH_PROBE_L || !out_valid_q))
    else $error("illegal search phase");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the autofocus hill-climb controller
// Drives sharpness items through coarse sweep, fine sweep and tracking under
// several register settings and random idling on both channels. Each result
// is compared with a lens-position predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import afhc_pkg::*;

  localparam int FOCUS_TOP     = 255;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int LONG_HOLD     = 150;
  localparam int DRAIN_CYCLES  = 24;
  localparam int PRINT_CAP     = 100;
  localparam int DIRECTED_N    = 25;
  localparam int DIRECTED_REFOCUS_AT = 21;

  // directed sharpness: sweep extremes and ties, then probe pairs that hit
  // right, widen, local max and zero sharpness with the threshold at zero
  localparam logic [SHARP_W-1:0] DIRECTED_SHARP [DIRECTED_N] = '{
    31'd0, 31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF, 31'h2AAAAAAA,
    31'd5, 31'h55555555, 31'h55555555, 31'd3, 31'd0,
    31'd12345, 31'd1000, 31'd100,
    31'd77, 31'd100, 31'd100,
    31'd9, 31'd50, 31'd100,
    31'd4, 31'd5, 31'd0,
    31'd6, 31'h7FFFFFFF, 31'd0
  };

  typedef struct packed {
    logic [POS_OUT_W-1:0] pos;
    logic [PHASE_W-1:0]   phase;
  } focus_move_t;

  class focus_scoreboard #(int LENS_MAX = 255);
    focus_move_t expected_moves[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned frames_seen;
    int unsigned restarts;
    int unsigned decisions[5];

    logic [STEP_W-1:0]  coarse_step;
    logic [FSTEP_W-1:0] fine_step;
    logic [STEP_W-1:0]  track_step;
    logic [STEP_W-1:0]  wide_step;
    logic [TH_W-1:0]    ratio_th;

    logic [PHASE_W-1:0] cur_phase;
    int                 lens;
    int                 right_limit;
    int                 probe_dist;
    logic [SHARP_W-1:0] best_sharp;
    int                 best_pos;
    bit                 first_sample;
    logic [SHARP_W-1:0] right_sharp;
    bit                 refocus_latched;

    function new();
      coarse_step     = RST_COARSE_STEP;
      fine_step       = RST_FINE_STEP;
      track_step      = RST_TRACK_STEP;
      wide_step       = RST_WIDE_TRACK_STEP;
      ratio_th        = RST_RATIO_THRESHOLD;
      cur_phase       = PH_COARSE;
      lens            = -1;
      right_limit     = LENS_MAX;
      probe_dist      = 0;
      best_sharp      = '0;
      best_pos        = 0;
      first_sample    = 1'b1;
      right_sharp     = '0;
      refocus_latched = 1'b0;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COARSE_STEP:     coarse_step = data[STEP_W-1:0];
        CFG_FINE_STEP:       fine_step   = data[FSTEP_W-1:0];
        CFG_TRACK_STEP:      track_step  = data[STEP_W-1:0];
        CFG_WIDE_TRACK_STEP: wide_step   = data[STEP_W-1:0];
        CFG_RATIO_THRESHOLD: ratio_th    = data[TH_W-1:0];
        default: ;
      endcase
    endfunction

    function int clip_lens(int v);
      if (v > LENS_MAX) return LENS_MAX;
      if (v < 0) return 0;
      return v;
    endfunction

    function longint abs64(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // running maximum; the first sample of a sweep always loads it
    function void track_max(logic [SHARP_W-1:0] s);
      if (first_sample || s > best_sharp) begin
        best_sharp = s;
        best_pos   = lens;
      end
      first_sample = 1'b0;
    endfunction

    // truncating ratio test; s is the current, r the right, l the left sharpness
    function logic [DEC_W-1:0] probe_decision(longint s, longint r, longint l);
      longint th;
      int     to_left;
      int     to_right;
      th       = longint'(ratio_th);
      to_left  = 0;
      to_right = 0;
      if (s == 0) return DEC_FLAT;
      if (probe_dist <= int'(track_step)) begin
        if (abs64(l - s) / s < th && abs64(r - s) / s < th) return DEC_FLAT;
        if ((s - r) / s >= th && (s - l) / s >= th) return DEC_WIDEN;
        if (abs64(l - s) / s >= th) begin
          if (l > s) to_left++;
          else to_right++;
        end
        if (abs64(r - s) / s >= th) begin
          if (r > s) to_right++;
          else to_left++;
        end
        if (to_left == to_right) return DEC_FLAT;
        return (to_left > to_right) ? DEC_LEFT : DEC_RIGHT;
      end
      if ((s - r) / s >= th && (s - l) / s >= th) return DEC_LOCAL_MAX;
      return DEC_FLAT;
    endfunction

    function void note_frame(logic [SHARP_W-1:0] s, logic rq);
      int                 cstep;
      int                 fstep;
      int                 half;
      logic [DEC_W-1:0]   dec;
      focus_move_t        mv;
      cstep = (coarse_step == 0) ? 1 : int'(coarse_step);
      fstep = (fine_step == 0) ? 1 : int'(fine_step);
      frames_seen++;
      if (rq) refocus_latched = 1'b1;
      case (cur_phase)
        PH_COARSE: begin
          track_max(s);
          if (lens > right_limit - cstep) begin
            half         = cstep / 2;
            right_limit  = clip_lens(best_pos + half);
            lens         = clip_lens(best_pos - half);
            first_sample = 1'b1;
            cur_phase    = PH_FINE;
          end else begin
            lens += cstep;
          end
        end
        PH_FINE: begin
          track_max(s);
          if (lens > right_limit - fstep) begin
            lens       = best_pos;
            probe_dist = int'(track_step);
            cur_phase  = PH_HOLD;
          end else begin
            lens += fstep;
          end
        end
        PH_HOLD: begin
          if (refocus_latched) begin
            refocus_latched = 1'b0;
            cur_phase       = PH_COARSE;
            right_limit     = LENS_MAX;
            first_sample    = 1'b1;
            restarts++;
          end else begin
            cur_phase   = PH_PROBE_R;
            right_sharp = '0;
            lens       += probe_dist;
          end
        end
        PH_PROBE_R: begin
          cur_phase   = PH_PROBE_L;
          right_sharp = s;
          lens       -= 2 * probe_dist;
        end
        PH_PROBE_L: begin
          // left sample is the current frame
          dec = probe_decision(longint'(s), longint'(right_sharp), longint'(s));
          decisions[dec]++;
          case (dec)
            DEC_RIGHT: begin
              lens      += 2 * probe_dist;
              probe_dist = int'(track_step);
            end
            DEC_LEFT: probe_dist = int'(track_step);
            DEC_WIDEN: begin
              probe_dist = int'(wide_step);
              lens      += probe_dist;
            end
            default: begin
              lens      += probe_dist;
              probe_dist = int'(track_step);
            end
          endcase
          cur_phase = PH_HOLD;
        end
        default: ;
      endcase
      lens        = clip_lens(lens);
      right_limit = clip_lens(right_limit);
      mv.pos      = lens[POS_OUT_W-1:0];
      mv.phase    = cur_phase;
      expected_moves.push_back(mv);
    endfunction

    task check_result(logic [POS_OUT_W-1:0] pos, logic [PHASE_W-1:0] ph);
      focus_move_t want;
      results_seen++;
      if (expected_moves.size() == 0) begin
        report("result with no item pending, position", 32'(pos), 32'(0));
        return;
      end
      want = expected_moves.pop_front();
      if (pos !== want.pos) report("focus_position", 32'(pos), 32'(want.pos));
      if (ph !== want.phase) report("search_phase", 32'(ph), 32'(want.phase));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SHARP_W-1:0]    frame_sharpness = '0;
  logic                  refocus_request = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_OUT_W-1:0]  focus_position;
  logic [PHASE_W-1:0]    search_phase;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  focus_scoreboard #(FOCUS_TOP) sb;
  int unsigned cycle_count = 0;
  int unsigned settings_used = 0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  bit          long_hold_req = 1'b0;

  autofocus_hill_climb_controller #(
    .FOCUS_MAX(FOCUS_TOP)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .frame_sharpness_i(frame_sharpness),
    .refocus_request_i(refocus_request),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .focus_position_o (focus_position),
    .search_phase_o   (search_phase),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, sb.expected_moves.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && !out_stall)
      sb.check_result(focus_position, search_phase);
  end

  // result side: random stall before each item, one long hold on request
  initial begin : result_sink
    int stall_len;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_len = LONG_HOLD;
      end else begin
        stall_len = sink_quiet ? 0 : $urandom_range(0, 3);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
    end
  end

  function automatic logic [SHARP_W-1:0] any_sharpness();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {SHARP_W{1'b1}};
      2:       return SHARP_W'($urandom_range(1, 15));
      3, 4:    return SHARP_W'($urandom_range(0, 5000));
      default: return SHARP_W'($urandom);
    endcase
  endfunction

  // picks the next sharpness from the predicted phase so that the probe
  // decision lands near the threshold often
  function automatic logic [SHARP_W-1:0] next_sharpness();
    longint q;
    if (sb.cur_phase == PH_PROBE_R && $urandom_range(0, 1) == 0)
      return SHARP_W'($urandom) | {2'b01, {(SHARP_W-2){1'b0}}};
    if (sb.cur_phase != PH_PROBE_L) return any_sharpness();
    q = longint'(sb.right_sharp) / (longint'(sb.ratio_th) + 1);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return sb.right_sharp;
      2:       return SHARP_W'(q);
      3:       return SHARP_W'(q + 1);
      4:       return SHARP_W'($urandom_range(1, 3));
      default: return any_sharpness();
    endcase
  endfunction

  task automatic send_frame(input logic [SHARP_W-1:0] s, input logic rq);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid        <= 1'b1;
    frame_sharpness <= s;
    refocus_request <= rq;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    sb.note_frame(s, rq);
  endtask

  task automatic run_frames(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        src_quiet  = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
      end
      send_frame(next_sharpness(), $urandom_range(0, 24) == 0);
    end
  endtask

  // every item yields one result, so an empty queue means the block is idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_moves.size() != 0);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk_i);
    sb.write_reg(idx, CFG_DATA_W'(value));
  endtask

  task automatic apply_settings(input int unsigned c, input int unsigned f,
                                input int unsigned t, input int unsigned w,
                                input int unsigned th);
    wait_drained();
    write_setting(CFG_COARSE_STEP, c);
    write_setting(CFG_FINE_STEP, f);
    write_setting(CFG_TRACK_STEP, t);
    write_setting(CFG_WIDE_TRACK_STEP, w);
    write_setting(CFG_RATIO_THRESHOLD, th);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int unsigned th_pick;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short sweeps and zero threshold so tracking decisions come quickly
    apply_settings(64, 16, 8, 16, 0);
    for (int i = 0; i < DIRECTED_N; i++)
      send_frame(DIRECTED_SHARP[i], i == DIRECTED_REFOCUS_AT);

    apply_settings(32'(RST_COARSE_STEP), 32'(RST_FINE_STEP), 32'(RST_TRACK_STEP),
                   32'(RST_WIDE_TRACK_STEP), 32'(RST_RATIO_THRESHOLD));
    run_frames(170);

    // threshold of one makes left moves reachable
    apply_settings(64, 16, 1, 64, 1);
    run_frames(80);
    long_hold_req = 1'b1;
    run_frames(90);

    // zero steps act as one: full-length single-step sweeps
    apply_settings(0, 0, 64, 1, 65535);
    run_frames(270);

    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 4))
        0:       th_pick = 0;
        1:       th_pick = 1;
        2:       th_pick = $urandom_range(2, 20);
        3:       th_pick = 65535;
        default: th_pick = $urandom_range(0, 65535);
      endcase
      apply_settings($urandom_range(2, 127), $urandom_range(0, 31),
                     $urandom_range(0, 127), $urandom_range(0, 127), th_pick);
      if (k == 1) begin
        run_frames(50);
        long_hold_req = 1'b1;
        run_frames(60);
      end else begin
        run_frames(110);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d frames over %0d register settings, %0d results checked, %0d mismatches",
             sb.frames_seen, settings_used, sb.results_seen, sb.mismatches);
    $display("probe outcomes: flat %0d, local max %0d, left %0d, right %0d, widen %0d; %0d restarts",
             sb.decisions[DEC_FLAT], sb.decisions[DEC_LOCAL_MAX], sb.decisions[DEC_LEFT],
             sb.decisions[DEC_RIGHT], sb.decisions[DEC_WIDEN], sb.restarts);
    if (sb.mismatches == 0 && sb.expected_moves.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- autofocus_hill_climb_controller.f -----
design/afhc_pkg.sv
design/autofocus_hill_climb_controller.sv
sim/tb_top.sv
